### rtl/core/hit_event_builder_with_veto_assert.svh
// Assertion macros for the hit event builder.
// All checks are clocked on i_clk and held off while i_rst_n is low.
`ifndef HIT_EVENT_BUILDER_WITH_VETO_ASSERT_SVH
`define HIT_EVENT_BUILDER_WITH_VETO_ASSERT_SVH

// Same-cycle implication.
`define HEBV_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HEBV_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/hebv_pkg.sv
package hebv_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MID_DEPTH  = 4;
    localparam int OUT_DEPTH  = 2;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx REG_ENERGY_THR = t_cfg_idx'(0);
    localparam t_cfg_idx REG_VETO_THR   = t_cfg_idx'(1);

    // crystal kinds; anything else is ignored
    localparam logic [3:0] CRY_MAIN   = 4'd0;
    localparam logic [3:0] CRY_VETO_A = 4'd1;
    localparam logic [3:0] CRY_VETO_B = 4'd2;

    localparam logic [15:0] ENERGY_THR_RST = 16'd480;
    localparam logic [15:0] VETO_THR_RST   = 16'd1600;
    localparam logic [23:0] SUM_MAX        = 24'hFF_FFFF;
    localparam logic [7:0]  COUNT_MAX      = 8'hFF;

    typedef struct packed {
        logic [31:0] event_number;
        logic [7:0]  detector;
        logic [3:0]  crystal;
        logic [15:0] hit_energy;
        logic        stream_end;
    } t_hit;

    // hit after threshold compares, as carried through the queue
    typedef struct packed {
        logic [31:0] event_number;
        logic [3:0]  det_lo;
        logic        in_range;
        logic [15:0] hit_energy;
        logic        main_hit;
        logic        veto_a;
        logic        veto_b;
        logic        stream_end;
    } t_hit_cls;

    typedef struct packed {
        logic [31:0] event_tag;
        logic [23:0] energy_total;
        logic        veto_first;
        logic        veto_second;
        logic [7:0]  multiplicity;
        logic        single_valid;
        logic [3:0]  single_detector;
        logic [15:0] single_energy;
        logic        last_of_run;
    } t_event;

endpackage

### rtl/core/hebv_fifo.sv
module hebv_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic         o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [AW:0]   r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (AW+1)'(DEPTH));

endmodule

### rtl/core/hebv_front.sv
module hebv_front #(
    parameter int DETECTORS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  hebv_pkg::t_cfg_idx  i_cfg_idx,
    input  hebv_pkg::t_cfg_data i_cfg_data,
    input  hebv_pkg::t_hit      i_hit,
    output hebv_pkg::t_hit_cls  o_cls
);

    import hebv_pkg::*;

    logic [15:0] r_energy_thr;
    logic [15:0] r_veto_thr;
    logic        w_over_veto;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy_thr <= ENERGY_THR_RST;
            r_veto_thr   <= VETO_THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ENERGY_THR: r_energy_thr <= i_cfg_data;
                REG_VETO_THR:   r_veto_thr   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_over_veto        = i_hit.hit_energy > r_veto_thr;
        o_cls.event_number = i_hit.event_number;
        o_cls.det_lo       = i_hit.detector[3:0];
        o_cls.in_range     = {1'b0, i_hit.detector} < 9'(DETECTORS);
        o_cls.hit_energy   = i_hit.hit_energy;
        o_cls.main_hit     = (i_hit.crystal == CRY_MAIN) && (i_hit.hit_energy > r_energy_thr);
        o_cls.veto_a       = (i_hit.crystal == CRY_VETO_A) && w_over_veto;
        o_cls.veto_b       = (i_hit.crystal == CRY_VETO_B) && w_over_veto;
        o_cls.stream_end   = i_hit.stream_end;
    end

endmodule

### rtl/core/hebv_back.sv
module hebv_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  hebv_pkg::t_hit_cls i_head,
    input  logic               i_res_ready,
    output logic               o_head_pop,
    output logic               o_res_push,
    output hebv_pkg::t_event   o_res
);

    import hebv_pkg::*;

    logic [31:0] r_open, n_open;
    logic [23:0] r_sum, n_sum;
    logic [7:0]  r_cnt, n_cnt;
    logic        r_va, n_va;
    logic        r_vb, n_vb;
    logic [3:0]  r_kd, n_kd;
    logic [15:0] r_ke, n_ke;
    logic        r_kr, n_kr;

    logic        w_go, w_id_change, w_split;
    logic [23:0] b_sum, h_sum, e_sum;
    logic [7:0]  b_cnt, h_cnt, e_cnt;
    logic        b_va, h_va, e_va;
    logic        b_vb, h_vb, e_vb;
    logic [3:0]  b_kd, h_kd, e_kd;
    logic [15:0] b_ke, h_ke, e_ke;
    logic        b_kr, h_kr, e_kr;
    logic [24:0] w_add;
    logic        w_single;

    always_comb begin
        w_go        = i_head_valid && i_res_ready;
        w_id_change = i_head.event_number != r_open;
        // id change plus end: close the old event now, keep the word at the head and replay it
        w_split     = w_id_change && i_head.stream_end;

        if (w_id_change) begin
            b_sum = '0; b_cnt = '0; b_va = 1'b0; b_vb = 1'b0;
            b_kd  = '0; b_ke  = '0; b_kr = 1'b0;
        end else begin
            b_sum = r_sum; b_cnt = r_cnt; b_va = r_va; b_vb = r_vb;
            b_kd  = r_kd;  b_ke  = r_ke;  b_kr = r_kr;
        end

        w_add = {1'b0, b_sum} + {9'd0, i_head.hit_energy};
        h_sum = b_sum;
        h_cnt = b_cnt;
        h_va  = b_va | i_head.veto_a;
        h_vb  = b_vb | i_head.veto_b;
        h_kd  = b_kd;
        h_ke  = b_ke;
        h_kr  = b_kr;
        if (i_head.main_hit) begin
            h_sum = w_add[24] ? SUM_MAX : w_add[23:0];
            h_cnt = (b_cnt == COUNT_MAX) ? b_cnt : b_cnt + 8'd1;
            h_kr  = i_head.in_range;
            if (i_head.in_range) begin
                h_kd = i_head.det_lo;
                h_ke = i_head.hit_energy;
            end
        end

        if (w_id_change) begin
            e_sum = r_sum; e_cnt = r_cnt; e_va = r_va; e_vb = r_vb;
            e_kd  = r_kd;  e_ke  = r_ke;  e_kr = r_kr;
        end else begin
            e_sum = h_sum; e_cnt = h_cnt; e_va = h_va; e_vb = h_vb;
            e_kd  = h_kd;  e_ke  = h_ke;  e_kr = h_kr;
        end

        w_single              = (e_cnt == 8'd1) && e_kr;
        o_res.event_tag       = r_open;
        o_res.energy_total    = e_sum;
        o_res.veto_first      = e_va;
        o_res.veto_second     = e_vb;
        o_res.multiplicity    = e_cnt;
        o_res.single_valid    = w_single;
        o_res.single_detector = w_single ? e_kd : 4'd0;
        o_res.single_energy   = w_single ? e_ke : 16'd0;
        o_res.last_of_run     = !w_split;

        o_res_push = w_go && (w_id_change || i_head.stream_end);
        o_head_pop = w_go && !w_split;

        n_open = r_open;
        n_sum  = r_sum; n_cnt = r_cnt; n_va = r_va; n_vb = r_vb;
        n_kd   = r_kd;  n_ke  = r_ke;  n_kr = r_kr;
        if (w_go) begin
            n_open = i_head.event_number;
            if (i_head.stream_end) begin
                n_sum = '0; n_cnt = '0; n_va = 1'b0; n_vb = 1'b0;
                n_kd  = '0; n_ke  = '0; n_kr = 1'b0;
            end else begin
                n_sum = h_sum; n_cnt = h_cnt; n_va = h_va; n_vb = h_vb;
                n_kd  = h_kd;  n_ke  = h_ke;  n_kr = h_kr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
            r_sum  <= '0;
            r_cnt  <= '0;
            r_va   <= 1'b0;
            r_vb   <= 1'b0;
            r_kd   <= '0;
            r_ke   <= '0;
            r_kr   <= 1'b0;
        end else begin
            r_open <= n_open;
            r_sum  <= n_sum;
            r_cnt  <= n_cnt;
            r_va   <= n_va;
            r_vb   <= n_vb;
            r_kd   <= n_kd;
            r_ke   <= n_ke;
            r_kr   <= n_kr;
        end
    end

endmodule

### rtl/core/hit_event_builder_with_veto.sv
// A result word reaches the output through the hit queue and then the result queue.
// Throughput: one hit per cycle while the result queue has room; a hit that both changes
// the event id and ends the stream is handled twice, once per result word it produces.
// A 4-deep hit queue and a 2-deep result queue let either side stall on its own.
// Reset (i_rst_n low, synchronous): queues empty, open event id and accumulators zero,
// energy threshold 480, veto threshold 1600.
module hit_event_builder_with_veto #(
    parameter int DETECTORS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    input  hebv_pkg::t_hit      i_hit,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output hebv_pkg::t_event    o_event,
    input  logic                i_cfg_we,
    input  hebv_pkg::t_cfg_idx  i_cfg_idx,
    input  hebv_pkg::t_cfg_data i_cfg_data
);

    import hebv_pkg::*;

    localparam int CLS_W = $bits(t_hit_cls);
    localparam int EV_W  = $bits(t_event);

    t_hit_cls         w_cls;
    t_hit_cls         w_mid_head;
    logic [CLS_W-1:0] w_mid_data;
    logic             w_in_push;
    logic             w_mid_empty;
    logic             w_mid_pop;

    t_event           w_res;
    logic [EV_W-1:0]  w_out_data;
    logic             w_res_push;
    logic             w_res_ready;
    logic             w_out_full;
    logic             w_out_pop;

    assign w_in_push   = push && !full;
    assign w_out_pop   = pop && !empty;
    assign w_res_ready = !w_out_full || w_out_pop;
    assign w_mid_head  = t_hit_cls'(w_mid_data);
    assign o_event     = t_event'(w_out_data);

    hebv_front #(
        .DETECTORS(DETECTORS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_hit      (i_hit),
        .o_cls      (w_cls)
    );

    hebv_fifo #(
        .W     (CLS_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_in_push),
        .i_data  (w_cls),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_data),
        .o_empty (w_mid_empty),
        .o_full  (full)
    );

    hebv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!w_mid_empty),
        .i_head       (w_mid_head),
        .i_res_ready  (w_res_ready),
        .o_head_pop   (w_mid_pop),
        .o_res_push   (w_res_push),
        .o_res        (w_res)
    );

    hebv_fifo #(
        .W     (EV_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .i_pop   (w_out_pop),
        .o_data  (w_out_data),
        .o_empty (empty),
        .o_full  (w_out_full)
    );

`include "hit_event_builder_with_veto_assert.svh"

    `HEBV_ASSERT_NOW(a_res_room, w_res_push, !w_out_full || w_out_pop, "result queue overrun")
    `HEBV_ASSERT_NOW(a_mid_pop_ok, w_mid_pop, !w_mid_empty, "hit queue underrun")
    `HEBV_ASSERT_NEXT(a_split_holds, w_res_push && !w_res.last_of_run, !w_mid_empty, "split hit lost")

endmodule
